// ===== design/aes128_block_encrypt_macros.svh =====
// Assertion macros for the AES-128 encryption pipeline.
// Included by the top level; no other dependencies.
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AES_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define AES_ASSERT(label, clk, rst_n, prop, msg)
`define AES_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== design/aes_pkg.sv =====
// Package for the AES-128 encryption pipeline: S-box, byte helpers, round
// functions and register indexes. No dependencies.
`default_nettype none
package aes_pkg;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned RegIdxW = 1;
  localparam logic [RegIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [RegIdxW-1:0] RegKeyLow  = 1'b1;

  typedef logic [127:0] block_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte n of a block sits at bits 127-8n down to 120-8n.
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned n);
    get_byte = b[127-8*n -: 8];
  endfunction

  // SubBytes and ShiftRows; byte index is row + 4 * column.
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = Sbox[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  // One step of the key schedule: next round key from the previous one.
  function automatic block_t next_key(input block_t k, input logic [7:0] rcon);
    block_t n;
    logic [31:0] w;
    w = {Sbox[k[23:16]] ^ rcon, Sbox[k[15:8]], Sbox[k[7:0]], Sbox[k[31:24]]};
    n[127:96] = k[127:96] ^ w;
    n[95:64]  = k[95:64] ^ n[127:96];
    n[63:32]  = k[63:32] ^ n[95:64];
    n[31:0]   = k[31:0] ^ n[63:32];
    next_key = n;
  endfunction
endpackage
`default_nettype wire

// ===== design/aes_stream_if.sv =====
// Valid/ready stream channel carrying one 128-bit block split in two halves.
// No dependencies.
`default_nettype none
interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, output data_high, output data_low, input ready);
  modport sink (input valid, input data_high, input data_low, output ready);
endinterface
`default_nettype wire

// ===== design/aes128_block_encrypt.sv =====
// AES-128 encryption pipeline with an APB key port.
// Each block passes through registers state_q[0] to state_q[NumRounds]; one block per cycle unless the output stalls.
// Each request carries its own round keys down the pipe, so a key write applies
// to the next request. A stalled output freezes every stage.
// Reset clears the valid bits and the key to zero.
// Depends on aes_pkg, aes_stream_if and the assertion macros.
`default_nettype none
`include "aes128_block_encrypt_macros.svh"
module aes128_block_encrypt
  import aes_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  aes_stream_if.sink       plain_i,
  aes_stream_if.source     cipher_o
);
  localparam logic [7:0] Rcon [NumRounds] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                             8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic [63:0] key_high_q, key_low_q;
  // rkey_q[r] holds round key r+1 of the request in stage r.
  block_t      rkey_q [NumRounds];
  block_t      state_q [NumRounds+1];
  logic        vld_q [NumRounds+1];
  logic        advance;
  logic        wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:3];
  assign wr_en   = psel && penable && pwrite && (paddr[2:0] == 3'b000);

  always_comb begin
    case (reg_idx)
      RegKeyHigh: prdata = key_high_q;
      RegKeyLow:  prdata = key_low_q;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        RegKeyHigh: key_high_q <= pwdata;
        RegKeyLow:  key_low_q  <= pwdata;
        default:    ;
      endcase
    end
  end

  // The whole pipe moves unless the output holds a result not taken.
  assign advance = !vld_q[NumRounds] || cipher_o.ready;
  assign plain_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r <= NumRounds; r++) vld_q[r] <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= plain_i.valid;
      for (int r = 1; r <= NumRounds; r++) vld_q[r] <= vld_q[r-1];
    end
  end

  // The key schedule runs one step per stage, beside the data it belongs to.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      state_q[0] <= {plain_i.data_high, plain_i.data_low} ^ {key_high_q, key_low_q};
      rkey_q[0]  <= next_key({key_high_q, key_low_q}, Rcon[0]);
      for (int r = 1; r < NumRounds; r++) begin
        state_q[r] <= mix_columns(sub_shift(state_q[r-1])) ^ rkey_q[r-1];
        rkey_q[r]  <= next_key(rkey_q[r-1], Rcon[r]);
      end
      state_q[NumRounds] <= sub_shift(state_q[NumRounds-1]) ^ rkey_q[NumRounds-1];
    end
  end

  assign cipher_o.valid     = vld_q[NumRounds];
  assign cipher_o.data_high = state_q[NumRounds][127:64];
  assign cipher_o.data_low  = state_q[NumRounds][63:0];

  `AES_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, cipher_o.valid && !cipher_o.ready,
                   cipher_o.valid && $stable(cipher_o.data_high), "stalled result changed")
  `AES_ASSERT_NEXT(a_in_flows, clk_i, rst_ni, plain_i.valid && plain_i.ready,
                   vld_q[0], "accepted request not captured")
  `AES_ASSERT(a_ready_stall, clk_i, rst_ni, !plain_i.ready |-> cipher_o.valid,
              "input stalled without pending result")
endmodule
`default_nettype wire
